### rtl/kcfu_pkg.sv
package kcfu_pkg;

    localparam int EdgeW   = 12;
    localparam int NumEdges = 4096;
    localparam int MaxLen  = 64;
    localparam int CntW    = 7;
    localparam int PtrW    = 6;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_ENTRY = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    localparam logic [1:0] ADDR_SCALE = 2'd0;
    localparam logic [1:0] ADDR_FUND  = 2'd1;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

### rtl/kcfu_div.sv
module kcfu_div (
    input  logic               clk,
    input  logic               rst_n,
    input  kcfu_pkg::div_req_t req,
    output kcfu_pkg::div_rsp_t rsp
);
    import kcfu_pkg::*;

    logic [63:0] quo_reg;
    logic [63:0] rem_reg;
    logic [63:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] trial;

    assign trial = {rem_reg, quo_reg[63]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                den_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                if (!trial[64])
                begin
                    rem_reg <= trial[63:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[62:0], quo_reg[63]};
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### rtl/kaczmarz_cycle_flow_update.sv
// Loads write the stores on acceptance; a read goes to S_RD, which loads the output
// register once it is free. A cycle entry stalls the input through S_E_W, S_E_M1,
// S_E_M2 and S_E_M3 (weight multiply and three partial products, all through one
// shared 32x32 multiplier). The final entry runs S_E_ACC and a 64-step radix-2 divide,
// then S_WB_RD, S_WB_MUL, S_WB_WR and S_OUT per write-back word, waiting on the output.
// Async active-low reset clears control, accumulators, fund (scale to 65536), not stores.
module kaczmarz_cycle_flow_update (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // edge_index[11:0], resistance[43:12], flow_in[75:44], sign[83:76],
    // cycle_index[99:84], report_counts[100], pad
    input  logic [103:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // edge_out[11:0], flow_out[43:12], fundamental_count[50:44], other_count[57:51],
    // zero_weight[58], saturated[59], pad
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import kcfu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_E_W, S_E_M1, S_E_M2, S_E_M3, S_E_ACC, S_DIV, S_WB_RD, S_WB_MUL,
        S_WB_WR, S_OUT
    } state_t;

    state_t state_reg;
    logic [31:0] scale_reg;
    logic [15:0] fund_reg;
    logic [31:0] res_mem [NumEdges];
    logic [31:0] flow_mem [NumEdges];
    logic [EdgeW-1:0] ent_edge [MaxLen];
    logic [7:0]  ent_sign [MaxLen];
    logic [31:0] res_q, flow_q;
    logic [EdgeW-1:0] cur_edge_reg;
    logic [7:0]  cur_sign_reg;
    logic [63:0] dot_reg;
    logic [63:0] wsum_reg;
    logic [CntW-1:0] cnt_reg, idx_reg;
    logic [47:0] w_reg;
    logic [39:0] fs_reg;
    logic        last_reg, rep_reg, fundq_reg, zw_reg, dneg_reg;
    logic [63:0] q_reg;
    logic        mneg_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] p_reg;
    logic [47:0] pm_reg;
    div_req_t dreq;
    div_rsp_t drsp;

    logic [11:0] in_edge;
    logic [31:0] in_res, in_flow;
    logic [7:0]  in_sign;
    logic [15:0] in_cidx;
    logic        in_rep;
    logic        s_acc, m_acc;
    logic        out_load, wb_fire;
    logic [PtrW-1:0] wb_ptr;

    assign in_edge = s_axis_tdata[11:0];
    assign in_res  = s_axis_tdata[43:12];
    assign in_flow = s_axis_tdata[75:44];
    assign in_sign = s_axis_tdata[83:76];
    assign in_cidx = s_axis_tdata[99:84];
    assign in_rep  = s_axis_tdata[100];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;
    assign out_load = (state_reg == S_RD || state_reg == S_WB_WR) &&
                      (!m_axis_tvalid || m_acc);
    assign wb_fire = out_load && (state_reg == S_WB_WR);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_FUND[0]) ? {16'd0, fund_reg} : scale_reg;
    assign wb_ptr = idx_reg[PtrW-1:0];

    // shared multiplier
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    kcfu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // magnitudes
    logic [31:0] fmag;
    logic [7:0]  smag;
    logic [39:0] fsm_full;
    logic [63:0] dmag;
    logic [48:0] mid_sum;
    logic [80:0] term_mag;
    logic [63:0] term;
    logic        tneg, tovf;
    logic [64:0] dsum;
    logic [63:0] dot_sat;
    always_comb
    begin
        fmag = flow_q[31] ? (32'd0 - flow_q) : flow_q;
        smag = cur_sign_reg[7] ? (8'd0 - cur_sign_reg) : cur_sign_reg;
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            S_E_W:
            begin
                mul_a = res_q;
                mul_b = scale_reg;
            end
            S_E_M1:
            begin
                mul_a = w_reg[31:0];
                mul_b = fs_reg[31:0];
            end
            S_E_M2:
            begin
                mul_a = {16'd0, w_reg[47:32]};
                mul_b = fs_reg[31:0];
            end
            S_E_M3:
            begin
                mul_a = w_reg[31:0];
                mul_b = {24'd0, fs_reg[39:32]};
            end
            S_WB_MUL:
            begin
                mul_a = q_reg[31:0];
                mul_b = {24'd0, smag};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
        fsm_full = {8'd0, fmag} * {32'd0, smag};
        // term = fs*w from partial products; both high parts nonzero means >= 2^64
        mid_sum = {1'b0, pm_reg} + {1'b0, mul_p[47:0]};
        term_mag = {17'd0, p_reg} + {mid_sum, 32'd0};
        tneg = flow_q[31] ^ cur_sign_reg[7];
        tovf = (fs_reg[39:32] != 8'd0 && w_reg[47:32] != 16'd0) ||
               (term_mag[80:63] != 18'd0 &&
                !(tneg && term_mag[80:63] == 18'd1 && term_mag[62:0] == 63'd0));
        if (fs_reg == 40'd0 || w_reg == 48'd0)
            term = 64'd0;
        else if (tovf)
            term = tneg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            term = tneg ? (64'd0 - term_mag[63:0]) : term_mag[63:0];
        dsum = {dot_reg[63], dot_reg} + {term[63], term};
        if (dsum[64] != dsum[63])
            dot_sat = dsum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            dot_sat = dsum[63:0];
        dmag = dot_reg[63] ? (64'd0 - dot_reg) : dot_reg;
    end

    logic [39:0] nv_mag;
    logic [39:0] fext;
    logic [40:0] nv;
    logic [31:0] nv_clamp;
    logic        nv_sat;
    logic        qbig;
    always_comb
    begin
        // any quotient of 2^32 or more with a nonzero sign always clamps
        qbig = (q_reg[63:32] != 32'd0);
        nv_mag = p_reg[39:0];
        fext = {{8{flow_q[31]}}, flow_q};
        nv = mneg_reg ? ({fext[39], fext} + {1'b0, nv_mag})
                      : ({fext[39], fext} - {1'b0, nv_mag});
        nv_sat = 1'b0;
        nv_clamp = nv[31:0];
        if (cur_sign_reg == 8'd0 || q_reg == 64'd0)
            nv_clamp = flow_q;
        else if (qbig)
        begin
            nv_sat = 1'b1;
            nv_clamp = mneg_reg ? 32'h7FFF_FFFF : 32'h8000_0000;
        end
        else if (!nv[40] && nv[39:31] != 9'd0)
        begin
            nv_sat = 1'b1;
            nv_clamp = 32'h7FFF_FFFF;
        end
        else if (nv[40] && nv[39:31] != 9'h1FF)
        begin
            nv_sat = 1'b1;
            nv_clamp = 32'h8000_0000;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc && s_axis_tuser == REQ_LOAD)
        begin
            res_mem[in_edge]  <= in_res;
            flow_mem[in_edge] <= in_flow;
        end
        else if (wb_fire)
            flow_mem[cur_edge_reg] <= nv_clamp;
        if (s_acc)
        begin
            res_q  <= res_mem[in_edge];
            flow_q <= flow_mem[in_edge];
        end
        else if (state_reg == S_WB_MUL)
        begin
            flow_q <= flow_mem[cur_edge_reg];
        end
        if (s_acc && s_axis_tuser == REQ_ENTRY && cnt_reg < CntW'(MaxLen))
        begin
            ent_edge[cnt_reg[PtrW-1:0]] <= in_edge;
            ent_sign[cnt_reg[PtrW-1:0]] <= in_sign;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scale_reg     <= 32'd65536;
            fund_reg      <= 16'd0;
            dot_reg       <= '0;
            wsum_reg      <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            m_axis_tvalid <= 1'b0;
            dreq.start    <= 1'b0;
        end
        else
        begin
            dreq.start <= 1'b0;
            if (psel && penable && pwrite)
            begin
                if (paddr[2] == ADDR_SCALE[0])
                    scale_reg <= pwdata;
                else
                    fund_reg <= pwdata[15:0];
            end
            if (out_load)
                m_axis_tvalid <= 1'b1;
            else if (m_acc)
                m_axis_tvalid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_acc)
                    begin
                        cur_edge_reg <= in_edge;
                        cur_sign_reg <= in_sign;
                        last_reg     <= s_axis_tlast;
                        rep_reg      <= in_rep;
                        fundq_reg    <= (in_cidx < fund_reg);
                        case (req_t'(s_axis_tuser))
                            REQ_READ: state_reg <= S_RD;
                            REQ_ENTRY:
                            begin
                                if (cnt_reg < CntW'(MaxLen))
                                begin
                                    cnt_reg   <= cnt_reg + 7'd1;
                                    state_reg <= S_E_W;
                                end
                                else if (s_axis_tlast)
                                    state_reg <= S_E_ACC;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_RD:
                begin
                    if (out_load)
                    begin
                        m_axis_tdata  <= {4'd0, 1'b0, 1'b0, 7'd0, 7'd0, flow_q, cur_edge_reg};
                        m_axis_tlast  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_E_W:
                begin
                    w_reg  <= mul_p[63:16];
                    fs_reg <= fsm_full;
                    state_reg <= S_E_M1;
                end
                S_E_M1:
                begin
                    p_reg <= mul_p;
                    state_reg <= S_E_M2;
                end
                S_E_M2:
                begin
                    pm_reg <= mul_p[47:0];
                    state_reg <= S_E_M3;
                end
                S_E_M3:
                begin
                    dot_reg  <= dot_sat;
                    wsum_reg <= wsum_reg + {16'd0, w_reg};
                    state_reg <= last_reg ? S_E_ACC : S_IDLE;
                end
                S_E_ACC:
                begin
                    zw_reg   <= (wsum_reg == 64'd0);
                    dneg_reg <= dot_reg[63];
                    dreq.dividend <= dmag;
                    dreq.divisor  <= wsum_reg;
                    dreq.start    <= 1'b1;
                    state_reg     <= S_DIV;
                end
                S_DIV:
                begin
                    if (drsp.done)
                    begin
                        q_reg     <= zw_reg ? 64'd0 : drsp.quotient;
                        idx_reg   <= '0;
                        state_reg <= (cnt_reg == '0) ? S_IDLE : S_WB_RD;
                        if (cnt_reg == '0)
                        begin
                            dot_reg  <= '0;
                            wsum_reg <= '0;
                        end
                    end
                end
                S_WB_RD:
                begin
                    cur_edge_reg <= ent_edge[wb_ptr];
                    cur_sign_reg <= ent_sign[wb_ptr];
                    state_reg    <= S_WB_MUL;
                end
                S_WB_MUL:
                begin
                    p_reg     <= mul_p;
                    mneg_reg  <= dneg_reg ^ cur_sign_reg[7];
                    state_reg <= S_WB_WR;
                end
                S_WB_WR:
                begin
                    if (out_load)
                    begin
                        m_axis_tdata <= {4'd0, nv_sat, zw_reg,
                                         (rep_reg && !fundq_reg) ? cnt_reg : 7'd0,
                                         (rep_reg && fundq_reg) ? cnt_reg : 7'd0,
                                         nv_clamp, cur_edge_reg};
                        m_axis_tlast  <= (idx_reg + 7'd1 == cnt_reg);
                        idx_reg   <= idx_reg + 7'd1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (m_acc)
                    begin
                        if (idx_reg == cnt_reg)
                        begin
                            dot_reg   <= '0;
                            wsum_reg  <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                            state_reg <= S_WB_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### tb/tb_kaczmarz_cycle_flow_update.sv
`timescale 1ns / 1ps

module tb_kaczmarz_cycle_flow_update;
    import kcfu_pkg::*;

    localparam int LIMIT = 2000000;
    localparam int DRAIN = 400;
    localparam logic signed [127:0] S64_MAX = 128'sh7fff_ffff_ffff_ffff;
    localparam logic signed [127:0] S64_MIN = -S64_MAX - 1;
    localparam logic signed [127:0] S32_MAX = 128'sh7fff_ffff;
    localparam logic signed [127:0] S32_MIN = -S32_MAX - 1;

    typedef struct {
        req_t        req;
        logic [11:0] edge_idx;
        logic [31:0] res;
        logic [31:0] flow;
        logic [7:0]  sgn;
        logic [15:0] cidx;
        logic        rep;
        logic        last;
    } word_t;

    typedef struct packed {
        logic [11:0] edge_idx;
        logic [31:0] flow;
        logic [6:0]  fcnt;
        logic [6:0]  ocnt;
        logic        zw;
        logic        sat;
        logic        last;
    } flow_rpt_t;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [2:0]   paddr = 0;
    logic [31:0]  pwdata = 0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = 0;
    logic [1:0]   s_axis_tuser = 0;
    logic         s_axis_tlast = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tlast;

    kaczmarz_cycle_flow_update uut (.*);

    always #5 clk = ~clk;

    word_t       pending[$];
    flow_rpt_t   exp_flows[$];
    int          edge_pool[$];
    bit          loaded[NumEdges];
    int          errors = 0;
    int          cyc = 0;
    bit          in_acc = 0;
    bit          hold_go = 0, hold_done = 0;
    int          hold_cnt = 0;
    int          gap = 0;
    int          rgap = 0;
    word_t       cur;

    // predictor state
    logic [31:0] cfg_scale = 32'h0001_0000;
    logic [15:0] cfg_fund = 0;
    logic [31:0] res_mem[NumEdges];
    logic [31:0] flow_mem[NumEdges];
    logic [11:0] ent_edge[MaxLen];
    logic [7:0]  ent_sign[MaxLen];
    logic signed [127:0] dot_acc = 0;
    logic [63:0] wt_acc = 0;
    int          ent_cnt = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rval();
        logic [31:0] ext[4];
        ext = '{32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h3_ffff);
            2: return ext[$urandom_range(0, 3)];
            default: return $urandom_range(0, 32'h3f_ffff) - 32'h1f_ffff;
        endcase
    endfunction

    task automatic apply_word(input word_t w);
        logic signed [31:0] fs;
        logic signed [7:0]  ss;
        logic signed [127:0] t, dmag, nv;
        logic [63:0] wv, dm, q;
        logic [6:0]  fc, oc;
        logic        zw, dneg, neg, sat;
        flow_rpt_t   r;
        case (w.req)
            REQ_LOAD:
            begin
                res_mem[w.edge_idx] = w.res;
                flow_mem[w.edge_idx] = w.flow;
            end
            REQ_READ:
            begin
                r = '{w.edge_idx, flow_mem[w.edge_idx], 7'd0, 7'd0, 1'b0, 1'b0, 1'b1};
                exp_flows.push_back(r);
            end
            REQ_ENTRY:
            begin
                if (ent_cnt < MaxLen) begin
                    wv = ({32'b0, res_mem[w.edge_idx]} * {32'b0, cfg_scale}) >> 16;
                    fs = flow_mem[w.edge_idx];
                    ss = w.sgn;
                    t = 128'(fs) * $signed({64'b0, wv}) * 128'(ss);
                    if (t > S64_MAX) t = S64_MAX;
                    if (t < S64_MIN) t = S64_MIN;
                    dot_acc = dot_acc + t;
                    if (dot_acc > S64_MAX) dot_acc = S64_MAX;
                    if (dot_acc < S64_MIN) dot_acc = S64_MIN;
                    wt_acc = wt_acc + wv;
                    ent_edge[ent_cnt] = w.edge_idx;
                    ent_sign[ent_cnt] = w.sgn;
                    ent_cnt++;
                end
                if (w.last) begin
                    zw = (wt_acc == 0);
                    dneg = dot_acc < 0;
                    dm = dneg ? 64'(-dot_acc) : 64'(dot_acc);
                    q = zw ? 64'd0 : dm / wt_acc;
                    fc = 0;
                    oc = 0;
                    if (w.rep) begin
                        if (w.cidx < cfg_fund) fc = 7'(ent_cnt);
                        else oc = 7'(ent_cnt);
                    end
                    for (int i = 0; i < ent_cnt; i++) begin
                        fs = flow_mem[ent_edge[i]];
                        ss = ent_sign[i];
                        nv = 128'(fs);
                        sat = 0;
                        if (ss != 0 && q != 0) begin
                            neg = dneg != (ss < 0);
                            if (q > 64'h2_0000_0000) begin
                                nv = neg ? S32_MAX : S32_MIN;
                                sat = 1;
                            end else begin
                                dmag = $signed({64'b0, q}) * (ss < 0 ? -128'(ss) : 128'(ss));
                                nv = neg ? nv + dmag : nv - dmag;
                                if (nv > S32_MAX) begin nv = S32_MAX; sat = 1; end
                                if (nv < S32_MIN) begin nv = S32_MIN; sat = 1; end
                            end
                        end
                        flow_mem[ent_edge[i]] = nv[31:0];
                        r = '{ent_edge[i], nv[31:0], fc, oc, zw, sat, i == ent_cnt - 1};
                        exp_flows.push_back(r);
                    end
                    dot_acc = 0;
                    wt_acc = 0;
                    ent_cnt = 0;
                end
            end
            default: ;
        endcase
    endtask

    // driver
    always @(negedge clk) begin
        logic v;
        v = s_axis_tvalid;
        if (in_acc) begin
            apply_word(cur);
            v = 0;
        end
        if (rst_n && !v) begin
            if (gap > 0) begin
                gap <= gap - 1;
            end else if (pending.size() > 0) begin
                cur = pending.pop_front();
                s_axis_tdata <= {3'b0, cur.rep, cur.cidx, cur.sgn, cur.flow, cur.res,
                                 cur.edge_idx};
                s_axis_tuser <= cur.req;
                s_axis_tlast <= cur.last;
                v = 1;
                gap <= pick_gap();
            end
        end
        s_axis_tvalid <= v;
    end

    // receiver
    always @(negedge clk) begin
        if (hold_go && !hold_done) begin
            hold_done <= 1;
            hold_cnt <= 3000;
            m_axis_tready <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 0;
        end else if (rgap > 0) begin
            rgap <= rgap - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= rst_n;
            if (m_axis_tready && m_axis_tvalid) rgap <= pick_gap();
        end
    end

    // monitor
    always @(posedge clk) begin
        flow_rpt_t act, want;
        in_acc <= s_axis_tvalid && s_axis_tready;
        if (m_axis_tvalid && m_axis_tready) begin
            act = '{m_axis_tdata[11:0], m_axis_tdata[43:12], m_axis_tdata[50:44],
                    m_axis_tdata[57:51], m_axis_tdata[58], m_axis_tdata[59], m_axis_tlast};
            if (exp_flows.size() == 0) begin
                errors++;
                $display("%0t: unexpected word edge=%0d flow=%h", $time,
                         act.edge_idx, act.flow);
            end else begin
                want = exp_flows.pop_front();
                if (act !== want) begin
                    errors++;
                    $display("%0t: mismatch exp edge=%0d flow=%h fc=%0d oc=%0d zw=%b sat=%b last=%b",
                             $time, want.edge_idx, want.flow, want.fcnt, want.ocnt,
                             want.zw, want.sat, want.last);
                    $display("%0t:          act edge=%0d flow=%h fc=%0d oc=%0d zw=%b sat=%b last=%b",
                             $time, act.edge_idx, act.flow, act.fcnt, act.ocnt,
                             act.zw, act.sat, act.last);
                end
            end
        end
    end

    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("[kaczmarz_cycle_flow_update] ERROR");
            $finish;
        end
    end

    task automatic push(input req_t rq, input int e, input logic [31:0] rs,
                        input logic [31:0] fl, input logic [7:0] sg, input logic last);
        word_t w;
        w.req = rq;
        w.edge_idx = 12'(e);
        w.res = rs;
        w.flow = fl;
        w.sgn = sg;
        w.cidx = 16'($urandom);
        w.rep = 1'($urandom);
        w.last = last;
        pending.push_back(w);
    endtask

    task automatic load_edge(input int e, input logic [31:0] rs, input logic [31:0] fl);
        push(REQ_LOAD, e, rs, fl, 8'($urandom), 1'($urandom));
        if (!loaded[e]) begin
            loaded[e] = 1;
            edge_pool.push_back(e);
        end
    endtask

    function automatic int pool_edge();
        return edge_pool[$urandom_range(0, edge_pool.size() - 1)];
    endfunction

    function automatic logic [7:0] rsign();
        if ($urandom_range(0, 1)) return 8'($urandom);
        return 8'($urandom_range(0, 6) - 3);
    endfunction

    task automatic push_cycle(input int len);
        int r;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 19);
            if (r == 0) load_edge(pool_edge(), rval(), rval());
            else if (r == 1) push(REQ_READ, pool_edge(), $urandom, $urandom, 8'($urandom),
                                  1'($urandom));
            else if (r == 2) push(REQ_NONE, $urandom, $urandom, $urandom, 8'($urandom),
                                  1'($urandom));
            push(REQ_ENTRY, pool_edge(), $urandom, $urandom, rsign(), i == len - 1);
        end
    endtask

    task automatic wait_idle();
        while (pending.size() > 0 || s_axis_tvalid || in_acc || exp_flows.size() > 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        paddr <= {idx[0], 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (idx == ADDR_SCALE) cfg_scale = val;
        else cfg_fund = val[15:0];
    endtask

    task automatic random_phase(input int n_items, input bit long_one);
        int goal, r;
        goal = pending.size() + n_items;
        if (long_one) push_cycle(MaxLen + 2);
        while (pending.size() < goal) begin
            r = $urandom_range(0, 19);
            if (r < 3) load_edge($urandom_range(0, NumEdges - 1), rval(), rval());
            else if (r < 5) push(REQ_READ, pool_edge(), $urandom, $urandom, 8'($urandom),
                                 1'($urandom));
            else if (r == 5) push(REQ_NONE, $urandom, $urandom, $urandom, 8'($urandom),
                                  1'($urandom));
            else if (r == 6) push_cycle(MaxLen);
            else push_cycle($urandom_range(1, 8));
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        reg_write(ADDR_SCALE, 32'h0001_0000);
        reg_write(ADDR_FUND, 32'd100);

        load_edge(0, 32'h0001_0000, 32'h0000_8000);
        load_edge(NumEdges - 1, 32'hffff_ffff, 32'h7fff_ffff);
        load_edge(5, 32'h0000_0000, 32'h8000_0000);
        load_edge(9, 32'h0002_0000, 32'hffff_0000);
        push(REQ_READ, 0, 0, 0, 0, 1);
        push(REQ_READ, NumEdges - 1, 0, 0, 0, 1);
        push(REQ_NONE, 7, 0, 0, 0, 1);
        push(REQ_ENTRY, 0, 0, 0, 8'h7f, 0);
        push(REQ_ENTRY, 9, 0, 0, 8'h80, 0);
        push(REQ_ENTRY, 0, 0, 0, 8'h00, 0);
        load_edge(9, 32'h0001_8000, 32'h0010_0000);
        push(REQ_ENTRY, 9, 0, 0, 8'h01, 1);
        push(REQ_ENTRY, 5, 0, 0, 8'h01, 1);
        push(REQ_ENTRY, NumEdges - 1, 0, 0, 8'h80, 0);
        push(REQ_ENTRY, 0, 0, 0, 8'h7f, 1);
        push(REQ_READ, 9, 0, 0, 0, 1);
        wait_idle();

        hold_go = 1;
        random_phase(80, 1);
        wait_idle();
        reg_write(ADDR_SCALE, 32'h0000_0000);
        reg_write(ADDR_FUND, 32'd0);
        random_phase(50, 0);
        wait_idle();
        reg_write(ADDR_SCALE, 32'hffff_ffff);
        reg_write(ADDR_FUND, 32'hffff);
        random_phase(80, 0);
        wait_idle();
        reg_write(ADDR_SCALE, $urandom_range(1, 32'h0002_0000));
        reg_write(ADDR_FUND, $urandom);
        random_phase(100, 0);
        wait_idle();

        if (errors == 0)
            $display("[kaczmarz_cycle_flow_update] OK");
        else
            $display("[kaczmarz_cycle_flow_update] ERROR");
        $finish;
    end
endmodule
